// ===== design/tfd_pkg.sv =====
package tfd_pkg;

    // Geometry and PWM scale.
    localparam int HALF_WIDTH = 320;
    localparam int PWM_RANGE  = 100;

    // Field widths.
    localparam int X_W      = 10;
    localparam int Y_W      = 9;
    localparam int GAIN_W   = 20;
    localparam int SIZE_W   = 11;
    localparam int DUTY_W   = 7;
    localparam int BOOST_W  = 6;
    localparam int XE_W     = 10;
    localparam int DXE_W    = XE_W + 1;
    localparam int SE_W     = 12;
    localparam int CW       = 13;
    localparam int SUM_W    = 32;
    localparam int MB_W     = SUM_W + 1;
    localparam int PROD_W   = GAIN_W + 1 + MB_W;
    localparam int ACC_W    = 60;
    localparam int FRAC_W   = 16;
    localparam int SPD_W    = ACC_W - FRAC_W;
    localparam int SHAMT_W  = 3;
    localparam int PC_W     = 4;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 20;
    localparam int MODE_W   = 2;

    // Stream payload widths.
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    // Register indexes.
    localparam logic [CIDX_W-1:0] REG_TURN_KP     = 3'd0;
    localparam logic [CIDX_W-1:0] REG_TURN_KI     = 3'd1;
    localparam logic [CIDX_W-1:0] REG_TURN_KD     = 3'd2;
    localparam logic [CIDX_W-1:0] REG_RUN_KP      = 3'd3;
    localparam logic [CIDX_W-1:0] REG_RUN_KD      = 3'd4;
    localparam logic [CIDX_W-1:0] REG_TARGET_SIZE = 3'd5;
    localparam logic [CIDX_W-1:0] REG_MAX_DUTY    = 3'd6;
    localparam logic [CIDX_W-1:0] REG_TURN_BOOST  = 3'd7;

    // Drive modes.
    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPIN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRIVE = 2'd2;

    // Multiplier operand pair selects.
    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_TP   = 3'd1;
    localparam logic [2:0] MUL_TI   = 3'd2;
    localparam logic [2:0] MUL_TD   = 3'd3;
    localparam logic [2:0] MUL_RP   = 3'd4;
    localparam logic [2:0] MUL_RD   = 3'd5;

    // Accumulator operations.
    localparam logic [2:0] ACC_HOLD  = 3'd0;
    localparam logic [2:0] ACC_LOAD  = 3'd1;
    localparam logic [2:0] ACC_ADD   = 3'd2;
    localparam logic [2:0] ACC_ADDSH = 3'd3;
    localparam logic [2:0] ACC_CLR   = 3'd4;

    // Jump conditions.
    localparam logic [1:0] J_NONE    = 2'd0;
    localparam logic [1:0] J_NOFOUND = 2'd1;
    localparam logic [1:0] J_NOSPIN  = 2'd2;
    localparam logic [1:0] J_ALWAYS  = 2'd3;

    // Program addresses that are jump targets.
    localparam logic [PC_W-1:0] STEP_DRIVE = 4'd12;
    localparam logic [PC_W-1:0] STEP_EMIT  = 4'd15;

    typedef struct packed {
        logic [2:0]         mul_sel;
        logic [2:0]         acc_op;
        logic [SHAMT_W-1:0] shamt;
        logic               derive;
        logic               upd_turn;
        logic               save_t;
        logic               spd_spin;
        logic               spd_drive;
        logic               upd_size;
        logic               emit;
        logic [1:0]         jcond;
        logic [PC_W-1:0]    jtarget;
    } tfd_uword_t;

    typedef struct packed {
        tfd_uword_t uw;
        logic       fire;
    } tfd_ctrl_t;

    typedef struct packed {
        logic found;
        logic spin;
        logic out_block;
    } tfd_cond_t;

    typedef struct packed {
        logic            busy;
        logic [PC_W-1:0] pc;
    } tfd_stat_t;

    // Control store.
    function automatic tfd_uword_t tfd_rom(input logic [PC_W-1:0] pc);
        tfd_uword_t w;
        w = '0;
        unique case (pc)
            4'd0:
            begin
                w.derive  = 1'b1;
                w.jcond   = J_NOFOUND;
                w.jtarget = STEP_EMIT;
            end
            4'd1:
            begin
                w.mul_sel = MUL_TP;
                w.acc_op  = ACC_LOAD;
            end
            4'd2:
            begin
                w.mul_sel = MUL_TI;
                w.acc_op  = ACC_ADD;
            end
            4'd3:
            begin
                w.mul_sel  = MUL_TD;
                w.acc_op   = ACC_ADD;
                w.upd_turn = 1'b1;
            end
            4'd4:
            begin
                w.save_t  = 1'b1;
                w.acc_op  = ACC_CLR;
                w.jcond   = J_NOSPIN;
                w.jtarget = STEP_DRIVE;
            end
            4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10:
            begin
                w.acc_op = ACC_ADDSH;
                w.shamt  = SHAMT_W'(pc - 4'd5);
            end
            4'd11:
            begin
                w.spd_spin = 1'b1;
                w.jcond    = J_ALWAYS;
                w.jtarget  = STEP_EMIT;
            end
            4'd12:
            begin
                w.mul_sel  = MUL_RP;
                w.acc_op   = ACC_LOAD;
                w.upd_size = 1'b1;
            end
            4'd13:
            begin
                w.mul_sel = MUL_RD;
                w.acc_op  = ACC_ADD;
            end
            4'd14:
            begin
                w.spd_drive = 1'b1;
            end
            4'd15:
            begin
                w.emit = 1'b1;
            end
            default:
            begin
                w = '0;
            end
        endcase
        return w;
    endfunction

    // Drop the Q16 fraction, rounding toward zero.
    function automatic logic signed [SPD_W-1:0] tfd_trunc(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] adj;
        adj = v + (v[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : '0);
        return adj[ACC_W-1:FRAC_W];
    endfunction

    // Clamp a speed and encode it as {reverse, duty}.
    function automatic logic [DUTY_W:0] tfd_encode(input logic signed [SPD_W-1:0] s,
                                                   input logic [DUTY_W-1:0]      lim);
        logic signed [SPD_W-1:0] lim_s;
        logic signed [SPD_W-1:0] c;
        logic signed [SPD_W-1:0] d;
        lim_s = SPD_W'(lim);
        if (s > lim_s)
            c = lim_s;
        else if (s < -lim_s)
            c = -lim_s;
        else
            c = s;
        if (c[SPD_W-1])
        begin
            d = SPD_W'(PWM_RANGE) + c;
            return {1'b1, d[DUTY_W-1:0]};
        end
        return {1'b0, c[DUTY_W-1:0]};
    endfunction

endpackage

// ===== design/tfd_sequencer.sv =====
module tfd_sequencer
    import tfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  tfd_cond_t cond,
    output tfd_ctrl_t ctrl,
    output tfd_stat_t stat
);

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    tfd_uword_t      uw;
    logic            fire;
    logic            taken;

    // Fetch the current control word.
    assign uw   = tfd_rom(pc_reg);
    assign fire = busy_reg && !(uw.emit && cond.out_block);

    // Jump condition decode.
    always_comb
    begin
        unique case (uw.jcond)
            J_NONE:    taken = 1'b0;
            J_NOFOUND: taken = !cond.found;
            J_NOSPIN:  taken = !cond.spin;
            J_ALWAYS:  taken = 1'b1;
            default:   taken = 1'b0;
        endcase
    end

    // Step counter.
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (!busy_reg)
        begin
            if (accept)
            begin
                busy_next = 1'b1;
                pc_next   = '0;
            end
        end
        else if (fire)
        begin
            if (uw.emit)
            begin
                busy_next = 1'b0;
                pc_next   = '0;
            end
            else if (taken)
                pc_next = uw.jtarget;
            else
                pc_next = PC_W'(pc_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign ctrl.uw   = uw;
    assign ctrl.fire = fire;
    assign stat.busy = busy_reg;
    assign stat.pc   = pc_reg;

endmodule

// ===== design/tfd_datapath.sv =====
module tfd_datapath
    import tfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  cfg_write,
    input  logic [CIDX_W-1:0]     cfg_index,
    input  logic [CDATA_W-1:0]    cfg_data,
    input  tfd_ctrl_t             ctrl,
    input  logic                  m_tready,
    output tfd_cond_t             cond,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [MODE_W-1:0]     m_tuser
);

    // Configuration registers.
    logic [GAIN_W-1:0]  turn_kp_reg, turn_ki_reg, turn_kd_reg, run_kp_reg, run_kd_reg;
    logic [SIZE_W-1:0]  target_size_reg;
    logic [DUTY_W-1:0]  max_duty_reg;
    logic [BOOST_W-1:0] turn_boost_reg;

    // Controller state.
    logic signed [XE_W-1:0]  prev_xe_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SE_W-1:0]  prev_se_reg;

    // Item registers.
    logic             found_reg;
    logic [X_W-1:0]   left_reg, right_reg;
    logic [Y_W-1:0]   top_reg, bottom_reg;
    logic signed [XE_W-1:0]  xe_reg;
    logic signed [SE_W-1:0]  se_reg;
    logic signed [DXE_W-1:0] dxe_reg;
    logic signed [CW-1:0]    dse_reg;
    logic             spin_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] t_reg;
    logic signed [SPD_W-1:0] spd_l_reg, spd_r_reg;

    // Result register.
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [MODE_W-1:0]     out_mode_reg;

    tfd_uword_t uw;
    assign uw = ctrl.uw;

    // Errors from the box.
    localparam logic signed [CW-1:0] HW_C     = CW'(HALF_WIDTH);
    localparam logic signed [CW-1:0] SPIN_LIM = CW'(HALF_WIDTH / 2);
    localparam logic signed [CW-1:0] XE_MAX   = CW'((1 << (XE_W - 1)) - 1);
    localparam logic signed [CW-1:0] XE_MIN   = -CW'(1 << (XE_W - 1));
    localparam logic signed [CW-1:0] SE_MAX   = CW'((1 << (SE_W - 1)) - 1);
    localparam logic signed [CW-1:0] SE_MIN   = -CW'(1 << (SE_W - 1));

    logic [CW-1:0]          lr_sum;
    logic signed [CW-1:0]   xe_raw, se_raw, hw_sum;
    logic signed [XE_W-1:0] xe_sat;
    logic signed [SE_W-1:0] se_sat;
    logic signed [CW-1:0]   xe_ext;

    always_comb
    begin
        lr_sum = CW'(left_reg) + CW'(right_reg);
        xe_raw = $signed({1'b0, lr_sum[CW-1:1]}) - HW_C;
        hw_sum = ($signed(CW'(bottom_reg)) - $signed(CW'(top_reg)))
               + ($signed(CW'(right_reg)) - $signed(CW'(left_reg)));
        se_raw = $signed(CW'(target_size_reg)) - hw_sum;
        if (xe_raw > XE_MAX)
            xe_sat = XE_MAX[XE_W-1:0];
        else if (xe_raw < XE_MIN)
            xe_sat = XE_MIN[XE_W-1:0];
        else
            xe_sat = xe_raw[XE_W-1:0];
        if (se_raw > SE_MAX)
            se_sat = SE_MAX[SE_W-1:0];
        else if (se_raw < SE_MIN)
            se_sat = SE_MIN[SE_W-1:0];
        else
            se_sat = se_raw[SE_W-1:0];
        xe_ext = CW'(xe_sat);
    end

    // Shared multiplier: unsigned gain against a signed operand.
    logic [GAIN_W-1:0]        mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;

    always_comb
    begin
        case (uw.mul_sel)
            MUL_TP:
            begin
                mul_a = turn_kp_reg;
                mul_b = MB_W'(xe_reg);
            end
            MUL_TI:
            begin
                mul_a = turn_ki_reg;
                mul_b = MB_W'(sum_reg);
            end
            MUL_TD:
            begin
                mul_a = turn_kd_reg;
                mul_b = MB_W'(dxe_reg);
            end
            MUL_RP:
            begin
                mul_a = run_kp_reg;
                mul_b = MB_W'(se_reg);
            end
            MUL_RD:
            begin
                mul_a = run_kd_reg;
                mul_b = MB_W'(dse_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = $signed({1'b0, mul_a}) * mul_b;
    end

    // Accumulator.
    always_comb
    begin
        case (uw.acc_op)
            ACC_LOAD:  acc_next = ACC_W'(prod);
            ACC_ADD:   acc_next = acc_reg + ACC_W'(prod);
            ACC_ADDSH: acc_next = turn_boost_reg[uw.shamt] ? acc_reg + (t_reg <<< uw.shamt)
                                                           : acc_reg;
            ACC_CLR:   acc_next = '0;
            default:   acc_next = acc_reg;
        endcase
    end

    // Integral update with 32-bit saturation.
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W + 1)'((64'sd1 <<< (SUM_W - 1)) - 1);
    localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W + 1)'(64'sd1 <<< (SUM_W - 1));

    always_comb
    begin
        sum_wide = (SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(xe_reg);
        if (sum_wide > SUM_MAX)
            sum_sat = SUM_MAX[SUM_W-1:0];
        else if (sum_wide < SUM_MIN)
            sum_sat = SUM_MIN[SUM_W-1:0];
        else
            sum_sat = sum_wide[SUM_W-1:0];
    end

    // Speed split and output encoding.
    logic signed [SPD_W-1:0] acc_int, t_int;
    logic [DUTY_W-1:0]       limit;
    logic [DUTY_W:0]         enc_r, enc_l;

    always_comb
    begin
        acc_int = tfd_trunc(acc_reg);
        t_int   = tfd_trunc(t_reg);
        if (10'(max_duty_reg) > 10'(PWM_RANGE))
            limit = DUTY_W'(PWM_RANGE);
        else
            limit = max_duty_reg;
        enc_r = tfd_encode(spd_r_reg, limit);
        enc_l = tfd_encode(spd_l_reg, limit);
    end

    // Configuration and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_kp_reg     <= GAIN_W'(655);
            turn_ki_reg     <= '0;
            turn_kd_reg     <= GAIN_W'(328);
            run_kp_reg      <= GAIN_W'(15991);
            run_kd_reg      <= GAIN_W'(52429);
            target_size_reg <= SIZE_W'(500);
            max_duty_reg    <= DUTY_W'(40);
            turn_boost_reg  <= BOOST_W'(9);
            prev_xe_reg     <= '0;
            sum_reg         <= '0;
            prev_se_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_TURN_KP:     turn_kp_reg     <= cfg_data;
                    REG_TURN_KI:     turn_ki_reg     <= cfg_data;
                    REG_TURN_KD:     turn_kd_reg     <= cfg_data;
                    REG_RUN_KP:      run_kp_reg      <= cfg_data;
                    REG_RUN_KD:      run_kd_reg      <= cfg_data;
                    REG_TARGET_SIZE: target_size_reg <= cfg_data[SIZE_W-1:0];
                    REG_MAX_DUTY:    max_duty_reg    <= cfg_data[DUTY_W-1:0];
                    REG_TURN_BOOST:  turn_boost_reg  <= cfg_data[BOOST_W-1:0];
                    default:         ;
                endcase
            end
            if (ctrl.fire && uw.upd_turn)
            begin
                prev_xe_reg <= xe_reg;
                sum_reg     <= sum_sat;
            end
            if (ctrl.fire && uw.upd_size)
                prev_se_reg <= se_reg;
            if (ctrl.fire && uw.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers of one item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg  <= s_tuser;
            left_reg   <= s_tdata[9:0];
            top_reg    <= s_tdata[18:10];
            right_reg  <= s_tdata[28:19];
            bottom_reg <= s_tdata[37:29];
        end
        if (ctrl.fire)
        begin
            if (uw.derive)
            begin
                xe_reg   <= xe_sat;
                se_reg   <= se_sat;
                dxe_reg  <= DXE_W'(xe_sat) - DXE_W'(prev_xe_reg);
                dse_reg  <= CW'(se_sat) - CW'(prev_se_reg);
                spin_reg <= (xe_ext > SPIN_LIM) || (xe_ext < -SPIN_LIM);
            end
            acc_reg <= acc_next;
            if (uw.save_t)
                t_reg <= acc_reg;
            if (uw.spd_spin)
            begin
                spd_l_reg <= acc_int;
                spd_r_reg <= -acc_int;
            end
            if (uw.spd_drive)
            begin
                spd_l_reg <= acc_int + t_int;
                spd_r_reg <= acc_int - t_int;
            end
            if (uw.emit)
            begin
                if (found_reg)
                begin
                    out_data_reg <= {enc_l, enc_r};
                    out_mode_reg <= spin_reg ? MODE_SPIN : MODE_DRIVE;
                end
                else
                begin
                    out_data_reg <= '0;
                    out_mode_reg <= MODE_STOP;
                end
            end
        end
    end

    assign cond.found     = found_reg;
    assign cond.spin      = spin_reg;
    assign cond.out_block = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_mode_reg;

endmodule

// ===== design/target_follow_differential_drive_pid.sv =====
// Channel  Direction  Payload
// s_*      in         tuser: target_found; tdata: box_left, box_top, box_right, box_bottom
// m_*      out        tuser: drive_mode; tdata: right_duty/reverse, left_duty/reverse
// cfg_*    in         cfg_index selects the register, cfg_data holds its value
//
// One item at a time runs through a 16-word microprogram over one shared multiplier.
// A no-target item jumps from the first step to emit, a driving item goes on to the
// drive steps, and a spinning item runs the six shift-add steps of the boost multiply.
// Reset clears the gains to their defaults and the controller history to zero.
// A stalled result holds the program at its last step; the next item can be accepted
// in the cycle after that step completes.
module target_follow_differential_drive_pid
    import tfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // box_left[9:0], box_top[18:10],
                                             // box_right[28:19], box_bottom[37:29]
    input  logic                  s_tuser,   // target_found
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // right_duty[6:0], right_reverse[7],
                                             // left_duty[14:8], left_reverse[15]
    output logic [MODE_W-1:0]     m_tuser,   // drive_mode
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CIDX_W-1:0]     cfg_index,
    input  logic [CDATA_W-1:0]    cfg_data
);

    tfd_ctrl_t ctrl;
    tfd_cond_t cond;
    tfd_stat_t stat;
    logic      accept;

    // Handshakes.
    assign s_tready  = !stat.busy;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    tfd_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cond   (cond),
        .ctrl   (ctrl),
        .stat   (stat)
    );

    tfd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .m_tready  (m_tready),
        .cond      (cond),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    // An accepted item starts the program.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> stat.busy && stat.pc == '0)
        else $error("sequencer did not start after an accepted item");

    // The step counter rests at zero while idle.
    a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.busy |-> stat.pc == '0)
        else $error("step counter moved while idle");

    // A stopped result carries zero duty and forward direction.
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == MODE_STOP |-> m_tdata == '0)
        else $error("stopped result with nonzero drive");

    // Spinning drives the two motors in opposite directions unless the result is zero.
    a_spin_dir: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == MODE_SPIN |-> m_tdata == '0 || m_tdata[7] != m_tdata[15])
        else $error("spin result with both motors in one direction");
`endif

endmodule

// ===== sim/tfd_checker.sv =====
`timescale 1ns / 1ps

// Watches the item and register channels of the steering controller, predicts every
// motor command from the accepted box items and compares it with what the block emits.
module tfd_checker
    import tfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [MODE_W-1:0]     m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CIDX_W-1:0]     cfg_index,
    input  logic [CDATA_W-1:0]    cfg_data,
    output int                    mismatches,
    output int                    awaited
);

    localparam longint SUM_MAX = (64'sd1 <<< 31) - 1;
    localparam longint SUM_MIN = -(64'sd1 <<< 31);

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              l_rev;
        logic [DUTY_W-1:0] l_duty;
        logic              r_rev;
        logic [DUTY_W-1:0] r_duty;
    } motor_cmd_t;

    // Shadow copy of the configuration registers.
    logic [GAIN_W-1:0]  turn_p;
    logic [GAIN_W-1:0]  turn_i;
    logic [GAIN_W-1:0]  turn_d;
    logic [GAIN_W-1:0]  run_p;
    logic [GAIN_W-1:0]  run_d;
    logic [SIZE_W-1:0]  size_goal;
    logic [DUTY_W-1:0]  duty_cap;
    logic [BOOST_W-1:0] spin_gain;

    // Controller history carried from frame to frame.
    longint last_xerr;
    longint err_sum;
    longint last_serr;

    motor_cmd_t cmd_q[$];

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Clamp a speed and turn it into {reverse, duty}.
    function automatic logic [DUTY_W:0] motor_code(input longint speed, input longint lim);
        longint s;
        s = clip(speed, -lim, lim);
        if (s >= 0)
            return {1'b0, DUTY_W'(s)};
        return {1'b1, DUTY_W'(PWM_RANGE + s)};
    endfunction

    // Expected command for one frame; updates the controller history as the block does.
    function automatic motor_cmd_t predict_cmd(input logic found,
                                               input logic [X_W-1:0] bl,
                                               input logic [Y_W-1:0] bt,
                                               input logic [X_W-1:0] br,
                                               input logic [Y_W-1:0] bb);
        motor_cmd_t c;
        longint     lim;
        longint     xe;
        longint     se;
        longint     turn;
        longint     boosted;
        longint     base;
        longint     rs;
        longint     ls;
        c = '0;
        if (!found)
            return c;
        lim = (duty_cap > PWM_RANGE) ? PWM_RANGE : longint'(duty_cap);
        xe = clip((longint'(bl) + longint'(br)) / 2 - HALF_WIDTH, -512, 511);
        se = clip(longint'(size_goal)
                  - ((longint'(bb) - longint'(bt)) + (longint'(br) - longint'(bl))),
                  -2048, 2047);
        // The integral term uses the sum from before this frame.
        turn = longint'(turn_p) * xe + longint'(turn_i) * err_sum
             + longint'(turn_d) * (xe - last_xerr);
        err_sum = clip(err_sum + xe, SUM_MIN, SUM_MAX);
        last_xerr = xe;
        if (xe > HALF_WIDTH / 2 || xe < -(HALF_WIDTH / 2))
        begin
            boosted = longint'(spin_gain) * turn;
            rs = (-boosted) / 65536;
            ls = boosted / 65536;
            c.mode = MODE_SPIN;
        end
        else
        begin
            base = (longint'(run_p) * se + longint'(run_d) * (se - last_serr)) / 65536;
            last_serr = se;
            rs = base - turn / 65536;
            ls = base + turn / 65536;
            c.mode = MODE_DRIVE;
        end
        {c.r_rev, c.r_duty} = motor_code(rs, lim);
        {c.l_rev, c.l_duty} = motor_code(ls, lim);
        return c;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t tfd_checker: %s", $time, msg);
    endtask

    task automatic apply_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
        case (idx)
            REG_TURN_KP:     turn_p = val[GAIN_W-1:0];
            REG_TURN_KI:     turn_i = val[GAIN_W-1:0];
            REG_TURN_KD:     turn_d = val[GAIN_W-1:0];
            REG_RUN_KP:      run_p = val[GAIN_W-1:0];
            REG_RUN_KD:      run_d = val[GAIN_W-1:0];
            REG_TARGET_SIZE: size_goal = val[SIZE_W-1:0];
            REG_MAX_DUTY:    duty_cap = val[DUTY_W-1:0];
            REG_TURN_BOOST:  spin_gain = val[BOOST_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    // Register writes, result checks, then new predictions, in that order on each clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        motor_cmd_t got;
        motor_cmd_t want;
        if (!rst_n)
        begin
            turn_p     = 655;
            turn_i     = 0;
            turn_d     = 328;
            run_p      = 15991;
            run_d      = 52429;
            size_goal  = 500;
            duty_cap   = 40;
            spin_gain  = 9;
            last_xerr  = 0;
            err_sum    = 0;
            last_serr  = 0;
            mismatches = 0;
            cmd_q.delete();
            awaited <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);

            if (m_tvalid && m_tready)
            begin
                got.r_duty = m_tdata[DUTY_W-1:0];
                got.r_rev  = m_tdata[DUTY_W];
                got.l_duty = m_tdata[2*DUTY_W:DUTY_W+1];
                got.l_rev  = m_tdata[2*DUTY_W+1];
                got.mode   = m_tuser;
                if (cmd_q.size() == 0)
                    note_mismatch($sformatf("unexpected result mode=%0d r=%0d/%0d l=%0d/%0d",
                                            got.mode, got.r_rev, got.r_duty,
                                            got.l_rev, got.l_duty));
                else
                begin
                    want = cmd_q.pop_front();
                    if (got.mode !== want.mode || got.r_duty !== want.r_duty
                        || got.r_rev !== want.r_rev || got.l_duty !== want.l_duty
                        || got.l_rev !== want.l_rev)
                        note_mismatch($sformatf(
                            {"expected mode=%0d r=%0d/%0d l=%0d/%0d, ",
                             "got mode=%0d r=%0d/%0d l=%0d/%0d"},
                            want.mode, want.r_rev, want.r_duty, want.l_rev, want.l_duty,
                            got.mode, got.r_rev, got.r_duty, got.l_rev, got.l_duty));
                end
            end

            if (s_tvalid && s_tready)
                cmd_q.push_back(predict_cmd(s_tuser,
                                            s_tdata[X_W-1:0],
                                            s_tdata[X_W+Y_W-1:X_W],
                                            s_tdata[2*X_W+Y_W-1:X_W+Y_W],
                                            s_tdata[2*X_W+2*Y_W-1:2*X_W+Y_W]));

            awaited <= cmd_q.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tfd_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_FRAMES = 250;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [MODE_W-1:0]     m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CIDX_W-1:0]     cfg_index;
    logic [CDATA_W-1:0]    cfg_data;

    int mismatches;
    int awaited;
    int frames_sent = 0;
    bit steady = 1'b0;
    bit hold_done = 1'b0;

    // Tracked box that drifts from frame to frame.
    int trk_cx = 320;
    int trk_cy = 240;
    int trk_hw = 100;
    int trk_hh = 100;

    target_follow_differential_drive_pid u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tfd_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Result side: random stalls, one long hold-off while frames keep coming.
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && frames_sent >= HOLD_AT)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                m_tready <= 1'b1;
            end
            else
                m_tready <= steady || ($urandom_range(0, 99) >= 18);
        end
    end

    function automatic int bound(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return GAIN_W'($urandom_range(0, 2000));
            1:       return GAIN_W'($urandom_range(0, 70000));
            2:       return GAIN_W'($urandom);
            default: return $urandom_range(0, 1) ? '1 : '0;
        endcase
    endfunction

    // Offer one frame item and wait until the block takes it.
    task automatic send_frame(input logic found,
                              input logic [X_W-1:0] bl,
                              input logic [Y_W-1:0] bt,
                              input logic [X_W-1:0] br,
                              input logic [Y_W-1:0] bb);
        while (!steady && $urandom_range(0, 99) < 18)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= found;
        s_tdata  <= IN_DATA_W'({bb, br, bt, bl});
        do
            @(posedge clk);
        while (!s_tready);
        frames_sent++;
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Stop offering items and let every outstanding result drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Register settings per phase: defaults with a nonzero integral gain, both extremes, then mixed values.
    task automatic program_regs(input int p);
        logic [GAIN_W-1:0]  g [5];
        logic [SIZE_W-1:0]  sz;
        logic [DUTY_W-1:0]  dc;
        logic [BOOST_W-1:0] bs;
        case (p)
            0:
            begin
                g  = '{655, 40, 328, 15991, 52429};
                sz = 500;
                dc = 40;
                bs = 9;
            end
            1:
            begin
                g  = '{default: '1};
                sz = '1;
                dc = '1;
                bs = '1;
            end
            2:
            begin
                g  = '{default: '0};
                sz = '0;
                dc = '0;
                bs = '0;
            end
            3:
            begin
                g  = '{655, 20, 328, 15991, 52429};
                sz = 300;
                dc = DUTY_W'(PWM_RANGE);
                bs = 1;
            end
            4:
            begin
                foreach (g[i])
                    g[i] = pick_gain();
                sz = SIZE_W'($urandom_range(0, 2047));
                dc = DUTY_W'(PWM_RANGE + 1);
                bs = BOOST_W'($urandom_range(0, 63));
            end
            default:
            begin
                foreach (g[i])
                    g[i] = pick_gain();
                sz = SIZE_W'($urandom_range(0, 2047));
                dc = DUTY_W'($urandom_range(0, 127));
                bs = BOOST_W'($urandom_range(0, 63));
            end
        endcase
        write_reg(REG_TURN_KP, g[0]);
        write_reg(REG_TURN_KI, g[1]);
        write_reg(REG_TURN_KD, g[2]);
        write_reg(REG_RUN_KP, g[3]);
        write_reg(REG_RUN_KD, g[4]);
        write_reg(REG_TARGET_SIZE, CDATA_W'(sz));
        write_reg(REG_MAX_DUTY, CDATA_W'(dc));
        write_reg(REG_TURN_BOOST, CDATA_W'(bs));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly a tracked target with random drift; some lost frames, noise and flipped boxes.
    task automatic random_frame();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 8)
            send_frame(1'b0, X_W'($urandom), Y_W'($urandom), X_W'($urandom), Y_W'($urandom));
        else if (kind < 18)
            send_frame(1'b1, X_W'($urandom), Y_W'($urandom), X_W'($urandom), Y_W'($urandom));
        else if (kind < 28)
            send_frame(1'b1, X_W'($urandom_range(0, 639)), Y_W'($urandom_range(0, 479)),
                       X_W'($urandom_range(0, 639)), Y_W'($urandom_range(0, 479)));
        else
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                trk_cx = $urandom_range(0, 639);
                trk_cy = $urandom_range(0, 479);
                trk_hw = $urandom_range(1, 220);
                trk_hh = $urandom_range(1, 200);
            end
            else
            begin
                trk_cx = bound(trk_cx + int'($urandom_range(0, 40)) - 20, 0, 639);
                trk_cy = bound(trk_cy + int'($urandom_range(0, 30)) - 15, 0, 479);
                trk_hw = bound(trk_hw + int'($urandom_range(0, 20)) - 10, 1, 320);
                trk_hh = bound(trk_hh + int'($urandom_range(0, 20)) - 10, 1, 240);
            end
            send_frame(1'b1,
                       X_W'(bound(trk_cx - trk_hw, 0, 639)),
                       Y_W'(bound(trk_cy - trk_hh, 0, 479)),
                       X_W'(bound(trk_cx + trk_hw, 0, 639)),
                       Y_W'(bound(trk_cy + trk_hh, 0, 479)));
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset gains.
        send_frame(1'b0, '1, '1, '1, '1);
        send_frame(1'b1, 0, 0, 0, 0);
        send_frame(1'b1, 220, 140, 420, 340);
        send_frame(1'b1, 220, 140, 420, 340);
        send_frame(1'b1, 639, 479, 639, 479);
        send_frame(1'b1, '1, '1, '1, '1);
        send_frame(1'b1, 0, 0, '1, '1);
        send_frame(1'b1, 600, 400, 40, 10);
        send_frame(1'b1, 400, 100, 560, 300);
        send_frame(1'b1, 401, 100, 561, 300);
        send_frame(1'b1, 400, 100, 561, 300);
        send_frame(1'b1, 100, 100, 220, 300);
        send_frame(1'b1, 100, 100, 218, 300);
        send_frame(1'b1, 100, 100, 219, 300);
        send_frame(1'b0, 0, 0, 0, 0);
        send_frame(1'b1, 300, 200, 340, 280);
        send_frame(1'b1, 0, 479, 639, 0);
        send_frame(1'b1, 639, 0, 0, 479);

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            program_regs(p);
            steady = (p == 6);
            for (int n = 0; n < PHASE_FRAMES; n++)
                random_frame();
        end
        steady = 1'b0;
        settle();
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tfd_pkg.sv
design/tfd_sequencer.sv
design/tfd_datapath.sv
design/target_follow_differential_drive_pid.sv
sim/tfd_checker.sv
sim/tb_top.sv
